// ===== src/pbts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared constants and types of the ready-bitmap task scheduler.
// ----------------------------------------------------------------------------
package pbts_pkg;

  localparam int unsigned NumLevelsDefault = 64;
  localparam int unsigned NumTasksDefault  = 64;
  localparam int unsigned LevelWidth       = 6;
  localparam int unsigned CountWidth       = 32;
  localparam logic [CountWidth-1:0] PermanentRunsReset = '1;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_STOP   = 3'd1,
    MODE_CHANGE = 3'd2,
    MODE_READY  = 3'd3,
    MODE_SUSP   = 3'd4,
    MODE_DONE   = 3'd5,
    MODE_TICK   = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SINGLE    = 2'd0,
    KIND_PERIODIC  = 2'd1,
    KIND_PERMANENT = 2'd2,
    KIND_ALT       = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [LevelWidth-1:0] task_req;
    logic [1:0]            task_kind;
    logic [CountWidth-1:0] count;
  } req_t;

  typedef struct packed {
    logic [LevelWidth-1:0] next_task;
    logic                  status;
    logic                  refilled;
    logic [CountWidth-1:0] runs_remaining;
  } rsp_t;

  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = i[2:0];
      end
    end
    return r;
  endfunction

  function automatic logic [CountWidth-1:0] load_for_kind(input logic [1:0] k,
      input logic [CountWidth-1:0] cnt, input logic [CountWidth-1:0] perm);
    logic [CountWidth-1:0] r;
    unique case (k)
      KIND_PERIODIC:  r = cnt;
      KIND_PERMANENT: r = perm;
      default:        r = CountWidth'(1);
    endcase
    return r;
  endfunction

endpackage

// ===== src/pbts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface pbts_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/priority_bitmap_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler
// Two-level ready bitmap scheduler with per-task state in a task memory.
// ----------------------------------------------------------------------------
// An ordinary word passes memory read, update, write back, then the result
// register. A tick, but for the first after reset, also picks and then
// rereads its task; a tick that hits the idle level also walks the task
// memory, one task at a time. One word is in flight at a time: no new word
// is accepted until its result is taken. Synchronous reset clears the
// bitmap, active flags and control state; task data is undefined.
module priority_bitmap_task_scheduler #(
  parameter int unsigned NUM_LEVELS = pbts_pkg::NumLevelsDefault,
  parameter int unsigned NUM_TASKS  = pbts_pkg::NumTasksDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  pbts_if.sink                           in_ch,
  pbts_if.source                         out_ch,
  input  logic                           cfg_we,
  input  logic [pbts_pkg::CountWidth-1:0] cfg_wdata
);
  import pbts_pkg::*;

  localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [LevelWidth-1:0] IdleLevel = LevelWidth'(NUM_LEVELS - 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_RD    = 8'b00000010,
    ST_EXEC  = 8'b00000100,
    ST_WB    = 8'b00001000,
    ST_WRD   = 8'b00010000,
    ST_WEXEC = 8'b00100000,
    ST_PICK  = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_t;

  state_t state;
  req_t   req;
  logic [CountWidth-1:0] permanent_runs;
  logic [7:0] ready_groups;
  logic [7:0] ready_rows [8];
  logic [NUM_TASKS-1:0] task_active;
  logic started;
  logic [LevelWidth-1:0] chosen_task;
  logic refill;
  logic tick_fin;
  logic [TW:0] walk;

  // Task memory word: kind, reload count, runs left.
  logic [2+2*CountWidth-1:0] tmem [NUM_TASKS];
  logic [2+2*CountWidth-1:0] rd_data;
  logic [TW-1:0] rd_addr;
  logic          wr_en;
  logic [TW-1:0] wr_addr;
  logic [2+2*CountWidth-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tmem[wr_addr] <= wr_data;
    end
    rd_data <= tmem[rd_addr];
  end

  logic in_tasks;
  logic [TW-1:0] t_idx;
  logic [2:0] grp;
  logic [2:0] bitp;
  logic [1:0] rd_kind;
  logic [CountWidth-1:0] rd_reload;
  logic [CountWidth-1:0] rd_runs;
  logic [2:0] py;
  logic [LevelWidth-1:0] pick_val;
  logic t_active;
  logic [TW-1:0] walk_idx;
  logic [LevelWidth-1:0] walk_lvl;
  rsp_t rsp;

  assign in_tasks  = 32'(req.task_req) < NUM_TASKS;
  assign t_idx     = TW'(req.task_req);
  assign grp       = req.task_req[5:3];
  assign bitp      = req.task_req[2:0];
  assign rd_kind   = rd_data[2+2*CountWidth-1 -: 2];
  assign rd_reload = rd_data[2*CountWidth-1 -: CountWidth];
  assign rd_runs   = rd_data[CountWidth-1:0];
  assign py        = low_bit(ready_groups);
  assign pick_val  = {py, low_bit(ready_rows[py])};
  assign t_active  = in_tasks && task_active[t_idx];
  assign walk_idx  = walk[TW-1:0];
  assign walk_lvl  = LevelWidth'(walk_idx);
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data = rsp;

  always_comb begin
    rd_addr = t_idx;
    if (state == ST_WRD) begin
      rd_addr = walk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      permanent_runs <= PermanentRunsReset;
    end else if (cfg_we) begin
      permanent_runs <= cfg_wdata;
    end
  end

  logic [7:0] row_sus;
  assign row_sus = ready_rows[grp] & ~(8'd1 << bitp);

  // The runs field takes a pending write to the task, else the value read.
  logic [CountWidth-1:0] runs_now;
  always_comb begin
    runs_now = rd_runs;
    if (wr_en && wr_addr == t_idx) begin
      runs_now = wr_data[CountWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ready_groups <= '0;
      for (int i = 0; i < 8; i++) begin
        ready_rows[i] <= '0;
      end
      task_active  <= '0;
      started      <= 1'b0;
      chosen_task  <= '0;
      wr_en        <= 1'b0;
      walk         <= '0;
      refill       <= 1'b0;
      tick_fin     <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            req      <= in_ch.data;
            refill   <= 1'b0;
            tick_fin <= 1'b0;
            state    <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_WB;
          rsp.status   <= 1'b0;
          rsp.refilled <= 1'b0;
          if (tick_fin) begin
            rsp.refilled <= refill;
          end else begin
            unique case (req.mode)
              MODE_CREATE: begin
                if (!in_tasks || task_active[t_idx]) begin
                  rsp.status <= 1'b1;
                end else begin
                  wr_en   <= 1'b1;
                  wr_addr <= t_idx;
                  wr_data <= {req.task_kind, req.count,
                              load_for_kind(req.task_kind, req.count, permanent_runs)};
                  task_active[t_idx] <= 1'b1;
                  if (32'(req.task_req) < NUM_LEVELS) begin
                    ready_groups[grp]    <= 1'b1;
                    ready_rows[grp][bitp] <= 1'b1;
                  end
                end
              end
              MODE_STOP: begin
                if (req.task_req == '0 || !in_tasks) begin
                  rsp.status <= 1'b1;
                end else begin
                  task_active[t_idx] <= 1'b0;
                  if (32'(req.task_req) < NUM_LEVELS) begin
                    ready_rows[grp] <= row_sus;
                    if (row_sus == '0) ready_groups[grp] <= 1'b0;
                  end
                end
              end
              MODE_CHANGE: begin
                if (!t_active) begin
                  rsp.status <= 1'b1;
                end else begin
                  wr_en   <= 1'b1;
                  wr_addr <= t_idx;
                  wr_data <= {rd_kind, req.count, rd_runs};
                end
              end
              MODE_READY: begin
                if (32'(req.task_req) < NUM_LEVELS) begin
                  ready_groups[grp]    <= 1'b1;
                  ready_rows[grp][bitp] <= 1'b1;
                end
              end
              MODE_SUSP: begin
                if (32'(req.task_req) < NUM_LEVELS) begin
                  ready_rows[grp] <= row_sus;
                  if (row_sus == '0) ready_groups[grp] <= 1'b0;
                end
              end
              MODE_DONE: begin
                if (in_tasks) begin
                  wr_en   <= 1'b1;
                  wr_addr <= t_idx;
                  wr_data <= {rd_kind, rd_reload, {CountWidth{1'b0}}};
                end
                if (req.task_req != IdleLevel && 32'(req.task_req) < NUM_LEVELS) begin
                  ready_rows[grp] <= row_sus;
                  if (row_sus == '0) ready_groups[grp] <= 1'b0;
                end
              end
              MODE_TICK: begin
                if (!started) begin
                  started     <= 1'b1;
                  chosen_task <= '0;
                end else begin
                  if (32'(req.task_req) < NUM_LEVELS) begin
                    ready_rows[grp] <= row_sus;
                    if (row_sus == '0) ready_groups[grp] <= 1'b0;
                  end
                  walk  <= '0;
                  state <= ST_PICK;
                end
              end
              default: begin
                rsp.status <= 1'b1;
              end
            endcase
          end
        end
        ST_WB: begin
          state              <= ST_OUT;
          rsp.next_task      <= (req.mode == MODE_TICK) ? chosen_task : pick_val;
          rsp.runs_remaining <= t_active ? runs_now : '0;
        end
        ST_PICK: begin
          if (!refill && pick_val == IdleLevel) begin
            refill <= 1'b1;
            walk   <= '0;
            state  <= ST_WRD;
          end else begin
            chosen_task <= pick_val;
            tick_fin    <= 1'b1;
            state       <= ST_RD;
          end
        end
        ST_WRD: begin
          state <= ST_WEXEC;
        end
        ST_WEXEC: begin
          if (task_active[walk_idx]) begin
            wr_en   <= 1'b1;
            wr_addr <= walk_idx;
            wr_data <= {rd_kind, rd_reload,
                        load_for_kind(rd_kind, rd_reload, permanent_runs)};
            if (32'(walk_idx) < NUM_LEVELS) begin
              ready_groups[walk_lvl[5:3]] <= 1'b1;
              ready_rows[walk_lvl[5:3]][walk_lvl[2:0]] <= 1'b1;
            end
          end
          if (32'(walk) == NUM_TASKS - 1) begin
            state <= ST_PICK;
          end else begin
            walk  <= walk + 1'b1;
            state <= ST_WRD;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/pbts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_checker
// Port-level checks on the scheduler handshakes.
// ----------------------------------------------------------------------------
module pbts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind priority_bitmap_task_scheduler pbts_checker u_pbts_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
